// ===== rtl/pll_pkg.sv =====
// Shared constants, codes, types and helper functions for the positional list engine.
`timescale 1ns / 1ps

package pll_pkg;

    localparam int LIST_CAPACITY = 32;

    localparam int ADDR_W  = $clog2(LIST_CAPACITY);
    localparam int CNT_W   = $clog2(LIST_CAPACITY + 1);
    localparam int OP_W    = 3;
    localparam int POS_W   = 6;
    localparam int DATA_W  = 32;
    localparam int STAT_W  = 2;
    localparam int FIELD_W = 6;
    localparam int CMP_W   = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    localparam logic [OP_W-1:0] OP_GET    = 3'd0;
    localparam logic [OP_W-1:0] OP_LOCATE = 3'd1;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd3;
    localparam logic [OP_W-1:0] OP_LENGTH = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic                     we;
        logic [ADDR_W-1:0]        waddr;
        logic signed [DATA_W-1:0] wdata;
        logic [ADDR_W-1:0]        raddr;
    } t_mem_req;

    typedef struct packed {
        logic                     valid;
        logic [STAT_W-1:0]        status;
        logic signed [DATA_W-1:0] value;
        logic [CNT_W-1:0]         found;
        logic [CNT_W-1:0]         count;
    } t_result;

    // Widens a count to the common compare width.
    function automatic logic [CMP_W-1:0] to_cmp(input logic [CNT_W-1:0] v);
        return CMP_W'(v);
    endfunction

    // Masks a count to the six-bit result field.
    function automatic logic [FIELD_W-1:0] to_field(input logic [CNT_W-1:0] v);
        logic [CMP_W-1:0] t;
        t = CMP_W'(v);
        return t[FIELD_W-1:0];
    endfunction

    // Takes the storage address bits of a position or index.
    function automatic logic [ADDR_W-1:0] to_addr(input logic [CMP_W-1:0] v);
        return v[ADDR_W-1:0];
    endfunction

endpackage

// ===== rtl/pll_if.sv =====
// Request and response channel interfaces of the positional list engine.
`timescale 1ns / 1ps

interface pll_req_if;
    logic                              valid;
    logic                              ready;
    logic [pll_pkg::OP_W-1:0]          operation;
    logic [pll_pkg::POS_W-1:0]         position;
    logic signed [pll_pkg::DATA_W-1:0] value_in;

    modport source (output valid, output operation, output position, output value_in,
                    input ready);
    modport sink   (input valid, input operation, input position, input value_in,
                    output ready);
endinterface

interface pll_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [pll_pkg::STAT_W-1:0]        status;
    logic signed [pll_pkg::DATA_W-1:0] value_out;
    logic [pll_pkg::FIELD_W-1:0]       found_position;
    logic [pll_pkg::FIELD_W-1:0]       length;

    modport source (output valid, output status, output value_out, output found_position,
                    output length, input ready);
    modport sink   (input valid, input status, input value_out, input found_position,
                    input length, output ready);
endinterface

// ===== rtl/positional_list_engine.sv =====
// Top level of the positional list engine: sequencer, element store and response register.
// Get makes at most one store read and length, clear and bad requests none; locate makes
// one store read per entry scanned, and insert or delete move one entry at a time, bound
// by the single write port and single read port of the store.
// One request is in flight at a time; a finished beat waits in the response register.
// Reset is synchronous and active low; it empties the list, the store contents are left as is.
`timescale 1ns / 1ps

module positional_list_engine (
    input  logic     i_clk,
    input  logic     i_rst_n,
    pll_req_if.sink  i_req,
    pll_rsp_if.source o_rsp
);

    // Store request from the sequencer and the registered read data back to it.
    pll_pkg::t_mem_req                 mem_req;
    logic signed [pll_pkg::DATA_W-1:0] mem_rdata;

    // Finished result, handed over when the response register is free.
    pll_pkg::t_result res;
    logic             res_ready;

    logic                              r_out_valid;
    logic [pll_pkg::STAT_W-1:0]        r_out_status;
    logic signed [pll_pkg::DATA_W-1:0] r_out_value;
    logic [pll_pkg::FIELD_W-1:0]       r_out_found;
    logic [pll_pkg::FIELD_W-1:0]       r_out_length;

    pll_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_mem       (mem_req),
        .i_rdata     (mem_rdata),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    pll_ram #(
        .WIDTH (pll_pkg::DATA_W),
        .DEPTH (pll_pkg::LIST_CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_waddr (mem_req.waddr),
        .i_wdata (mem_req.wdata),
        .i_raddr (mem_req.raddr),
        .o_rdata (mem_rdata)
    );

    // The response register takes a new beat when it is empty or its beat is leaving.
    assign res_ready = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res.valid;
        end
        if (res_ready && res.valid) begin
            r_out_status <= res.status;
            r_out_value  <= res.value;
            r_out_found  <= pll_pkg::to_field(res.found);
            r_out_length <= pll_pkg::to_field(res.count);
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_out_status;
    assign o_rsp.value_out      = r_out_value;
    assign o_rsp.found_position = r_out_found;
    assign o_rsp.length         = r_out_length;

`ifndef SYNTHESIS
    // The element count never passes the capacity of the store.
    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.valid |-> (pll_pkg::to_cmp(res.count) <=
                       pll_pkg::CMP_W'(pll_pkg::LIST_CAPACITY)))
        else $error("element count above capacity");

    // A full status is only given when the store really is full.
    a_full_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res.valid && res.status == pll_pkg::ST_FULL) |->
        (pll_pkg::to_cmp(res.count) == pll_pkg::CMP_W'(pll_pkg::LIST_CAPACITY)))
        else $error("full status with room left");

    // A found position always lies inside the list and comes with an ok status.
    a_found_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res.valid && res.found != '0) |->
        (res.found <= res.count && res.status == pll_pkg::ST_OK))
        else $error("found position outside the list");

    // No new request is taken while a result is still waiting to be handed over.
    a_no_accept_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.valid |-> !i_req.ready)
        else $error("request accepted while a result is pending");
`endif

endmodule

// ===== rtl/pll_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module pll_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/pll_ctrl.sv =====
// Sequencer that walks the element store one entry per cycle for locate, insert and delete requests.
`timescale 1ns / 1ps

module pll_ctrl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    pll_req_if.sink                           i_req,
    output pll_pkg::t_mem_req                 o_mem,
    input  logic signed [pll_pkg::DATA_W-1:0] i_rdata,
    output pll_pkg::t_result                  o_res,
    input  logic                              i_res_ready
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_GET  = 3'd1;
    localparam logic [2:0] S_LOC  = 3'd2;
    localparam logic [2:0] S_INS  = 3'd3;
    localparam logic [2:0] S_INSW = 3'd4;
    localparam logic [2:0] S_DEL0 = 3'd5;
    localparam logic [2:0] S_DEL  = 3'd6;
    localparam logic [2:0] S_HOLD = 3'd7;

    localparam logic [pll_pkg::CMP_W-1:0] C_ONE = pll_pkg::CMP_W'(1);
    localparam logic [pll_pkg::CMP_W-1:0] C_TWO = pll_pkg::CMP_W'(2);
    localparam logic [pll_pkg::CMP_W-1:0] C_CAP = pll_pkg::CMP_W'(pll_pkg::LIST_CAPACITY);
    localparam logic [pll_pkg::CNT_W-1:0] K_ONE = pll_pkg::CNT_W'(1);

    logic [2:0]                        r_state, n_state;
    logic [pll_pkg::CMP_W-1:0]         r_pos, n_pos;
    logic signed [pll_pkg::DATA_W-1:0] r_val, n_val;
    logic [pll_pkg::CNT_W-1:0]         r_k, n_k;
    logic [pll_pkg::CNT_W-1:0]         r_count, n_count;
    logic [pll_pkg::STAT_W-1:0]        r_status, n_status;
    logic signed [pll_pkg::DATA_W-1:0] r_value, n_value;
    logic [pll_pkg::CNT_W-1:0]         r_found, n_found;

    logic [pll_pkg::CMP_W-1:0] pos_in;
    logic [pll_pkg::CMP_W-1:0] cnt_x;
    logic [pll_pkg::CMP_W-1:0] k_x;

    always_comb begin
        n_state  = r_state;
        n_pos    = r_pos;
        n_val    = r_val;
        n_k      = r_k;
        n_count  = r_count;
        n_status = r_status;
        n_value  = r_value;
        n_found  = r_found;
        o_mem    = '0;

        // Position zero behaves as the first position.
        pos_in = pll_pkg::CMP_W'(i_req.position);
        if (pos_in == '0) begin
            pos_in = C_ONE;
        end
        cnt_x = pll_pkg::to_cmp(r_count);
        k_x   = pll_pkg::to_cmp(r_k);

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_pos    = pos_in;
                    n_val    = i_req.value_in;
                    n_status = pll_pkg::ST_OK;
                    n_value  = '0;
                    n_found  = '0;
                    n_state  = S_HOLD;
                    case (i_req.operation)
                        pll_pkg::OP_GET: begin
                            if (pos_in > cnt_x) begin
                                n_status = pll_pkg::ST_MISS;
                            end else begin
                                o_mem.raddr = pll_pkg::to_addr(pos_in - C_ONE);
                                n_state     = S_GET;
                            end
                        end
                        pll_pkg::OP_LOCATE: begin
                            if (r_count == '0) begin
                                n_status = pll_pkg::ST_MISS;
                            end else begin
                                n_k     = '0;
                                n_state = S_LOC;
                            end
                        end
                        pll_pkg::OP_INSERT: begin
                            if (pos_in > cnt_x + C_ONE) begin
                                n_status = pll_pkg::ST_MISS;
                            end else if (cnt_x >= C_CAP) begin
                                n_status = pll_pkg::ST_FULL;
                            end else if (pos_in - C_ONE == cnt_x) begin
                                // Append: nothing to move.
                                o_mem.we    = 1'b1;
                                o_mem.waddr = pll_pkg::to_addr(cnt_x);
                                o_mem.wdata = i_req.value_in;
                                n_count     = r_count + K_ONE;
                            end else begin
                                n_k         = r_count;
                                o_mem.raddr = pll_pkg::to_addr(cnt_x - C_ONE);
                                n_state     = S_INS;
                            end
                        end
                        pll_pkg::OP_DELETE: begin
                            if (pos_in > cnt_x) begin
                                n_status = pll_pkg::ST_MISS;
                            end else begin
                                o_mem.raddr = pll_pkg::to_addr(pos_in - C_ONE);
                                n_k         = pll_pkg::CNT_W'(pos_in - C_ONE);
                                n_state     = S_DEL0;
                            end
                        end
                        pll_pkg::OP_LENGTH: begin
                            n_status = pll_pkg::ST_OK;
                        end
                        pll_pkg::OP_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                            n_status = pll_pkg::ST_MISS;
                        end
                    endcase
                end
            end
            S_GET: begin
                n_value = i_rdata;
                n_state = S_HOLD;
            end
            S_LOC: begin
                if (i_rdata == r_val) begin
                    n_found = r_k + K_ONE;
                    n_state = S_HOLD;
                end else if (k_x + C_ONE == cnt_x) begin
                    n_status = pll_pkg::ST_MISS;
                    n_state  = S_HOLD;
                end else begin
                    n_k         = r_k + K_ONE;
                    o_mem.raddr = pll_pkg::to_addr(k_x + C_ONE);
                end
            end
            S_INS: begin
                // Move one entry up while the next lower one is being read.
                o_mem.we    = 1'b1;
                o_mem.waddr = pll_pkg::to_addr(k_x);
                o_mem.wdata = i_rdata;
                if (k_x == r_pos) begin
                    n_state = S_INSW;
                end else begin
                    n_k         = r_k - K_ONE;
                    o_mem.raddr = pll_pkg::to_addr(k_x - C_TWO);
                end
            end
            S_INSW: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = pll_pkg::to_addr(r_pos - C_ONE);
                o_mem.wdata = r_val;
                n_count     = r_count + K_ONE;
                n_state     = S_HOLD;
            end
            S_DEL0: begin
                n_value = i_rdata;
                if (k_x + C_ONE >= cnt_x) begin
                    n_count = r_count - K_ONE;
                    n_state = S_HOLD;
                end else begin
                    o_mem.raddr = pll_pkg::to_addr(k_x + C_ONE);
                    n_state     = S_DEL;
                end
            end
            S_DEL: begin
                // Move one entry down while the next higher one is being read.
                o_mem.we    = 1'b1;
                o_mem.waddr = pll_pkg::to_addr(k_x);
                o_mem.wdata = i_rdata;
                if (k_x + C_TWO == cnt_x) begin
                    n_count = r_count - K_ONE;
                    n_state = S_HOLD;
                end else begin
                    n_k         = r_k + K_ONE;
                    o_mem.raddr = pll_pkg::to_addr(k_x + C_TWO);
                end
            end
            S_HOLD: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_pos    <= n_pos;
        r_val    <= n_val;
        r_k      <= n_k;
        r_status <= n_status;
        r_value  <= n_value;
        r_found  <= n_found;
    end

    assign i_req.ready  = (r_state == S_IDLE);
    assign o_res.valid  = (r_state == S_HOLD);
    assign o_res.status = r_status;
    assign o_res.value  = r_value;
    assign o_res.found  = r_found;
    assign o_res.count  = r_count;

endmodule
